### sv/atm_pkg.sv
// Shared types and constants for the alarm table minute matcher.
// No dependencies; imported by atm_cell and the top level.
package atm_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_TICK   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef struct packed {
      logic       en;
      logic [4:0] hour;
      logic [5:0] minute;
      logic       rp;
      logic [2:0] wd;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic       add;       // write new_entry at pos
      logic       del;       // shift down from pos
      logic       scan;      // walk looks for a match
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] today_wd;
      entry_type  new_entry;
   } cell_cmd_type;

endpackage

### sv/atm_cell.sv
// One table slot: holds an entry, takes writes and shifts, and processes
// the walking token. Depends on atm_pkg.
module atm_cell
   import atm_pkg::*;
#(
   parameter int POS = 0,
   parameter int CW  = 7,
   parameter int IW  = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic [CW-1:0] pos,
   input  logic [CW-1:0] count,
   input  entry_type     next_entry,
   output entry_type     entry_out,
   input  logic          tok_in,
   input  logic [CW-1:0] cnt_in,
   input  logic          found_in,
   input  logic [IW-1:0] idx_in,
   output logic          tok_out,
   output logic [CW-1:0] cnt_out,
   output logic          found_out,
   output logic [IW-1:0] idx_out
);

   localparam logic [CW-1:0] MY_POS = CW'(POS);
   localparam logic [IW-1:0] MY_IDX = IW'(POS);

   entry_type     entry_ff;
   logic          tok_ff, found_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff;
   logic          in_range, wd_ok, hit, applies;

   assign in_range = MY_POS < count;
   assign wd_ok    = !entry_ff.rp || (entry_ff.wd == cmd.today_wd);
   assign hit      = tok_in && cmd.scan && in_range && !found_in && entry_ff.en
                     && entry_ff.hour == cmd.hour && entry_ff.minute == cmd.minute && wd_ok;
   // a one-shot that fires now no longer counts for today
   assign applies  = tok_in && in_range && entry_ff.en && wd_ok && !(hit && !entry_ff.rp);

   always_ff @(posedge clock) begin
      if (cmd.add && pos == MY_POS) begin
         entry_ff <= cmd.new_entry;
      end else if (cmd.del && MY_POS >= pos) begin
         entry_ff <= next_entry;
      end else if (hit && !entry_ff.rp) begin
         entry_ff.en <= 1'b0;
      end
      cnt_ff   <= cnt_in + CW'(applies);
      idx_ff   <= hit ? MY_IDX : idx_in;
      found_ff <= found_in || hit;
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry_out = entry_ff;
   assign tok_out   = tok_ff;
   assign cnt_out   = cnt_ff;
   assign found_out = found_ff;
   assign idx_out   = idx_ff;

endmodule

### sv/alarm_table_minute_matcher.sv
// Alarm table with minute matcher: top level, a row of atm_cell slots.
// Depends on atm_pkg and atm_cell.
//
//  channel | ports                                   | direction
//  request | req_valid/req_ready, opcode..entry_index | in
//  result  | rsp_valid/rsp_ready, status..today_total | out
//
// Each request first updates the slots (add, delete shift, tick latch),
// then a token walks the row one slot a cycle, gathering the first
// match and the today count.
// Reset empties the table and clears the last minute seen; no clearing pass.
// A waiting result does not block the next request once it is being taken;
// a new request is refused while a walk is in flight.
module alarm_table_minute_matcher
   import atm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [4:0] req_hour,
   input  logic [5:0] req_minute,
   input  logic [2:0] req_weekday,
   input  logic       req_repeating,
   input  logic [5:0] req_entry_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_fired,
   output logic [5:0] rsp_fired_index,
   output logic [6:0] rsp_entry_total,
   output logic [6:0] rsp_today_total
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int XW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

   logic          busy_ff, start_ff, scan_ff, rsp_valid_ff;
   logic [CW-1:0] count_ff;
   logic [6:0]    last_min_ff;
   logic [2:0]    wd_ff;
   logic [4:0]    hour_ff;
   logic [5:0]    min_ff;
   logic [1:0]    status_ff, rsp_status_ff;
   logic          rsp_fired_ff;
   logic [5:0]    rsp_idx_ff;
   logic [6:0]    rsp_total_ff, rsp_today_ff;

   logic          accept, bad_index;
   logic          add_go, del_go;
   logic [CW-1:0] pos;
   cell_cmd_type  cmd;

   entry_type     entries [TABLE_DEPTH];
   logic          tok     [TABLE_DEPTH+1];
   logic [CW-1:0] cnt     [TABLE_DEPTH+1];
   logic          found   [TABLE_DEPTH+1];
   logic [IW-1:0] idx     [TABLE_DEPTH+1];

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign bad_index = XW'(req_entry_index) >= XW'(count_ff);
   assign add_go    = accept && req_opcode == OP_ADD && count_ff != FULL;
   assign del_go    = accept && req_opcode == OP_DELETE && !bad_index;
   assign pos       = (req_opcode == OP_ADD) ? count_ff : CW'(req_entry_index);

   always_comb begin
      cmd                  = '0;
      cmd.add              = add_go;
      cmd.del              = del_go;
      cmd.scan             = scan_ff;
      cmd.hour             = hour_ff;
      cmd.minute           = min_ff;
      cmd.today_wd         = wd_ff;
      cmd.new_entry.en     = 1'b1;
      cmd.new_entry.hour   = req_hour;
      cmd.new_entry.minute = req_minute;
      cmd.new_entry.rp     = req_repeating;
      cmd.new_entry.wd     = req_weekday;
   end

   assign tok[0]   = start_ff;
   assign cnt[0]   = '0;
   assign found[0] = 1'b0;
   assign idx[0]   = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type nxt;
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nxt = entries[i];
      end else begin : g_mid
         assign nxt = entries[i+1];
      end
      atm_cell #(.POS(i), .CW(CW), .IW(IW)) u_cell (
         .clock, .reset, .cmd, .pos, .count(count_ff),
         .next_entry(nxt), .entry_out(entries[i]),
         .tok_in(tok[i]), .cnt_in(cnt[i]), .found_in(found[i]), .idx_in(idx[i]),
         .tok_out(tok[i+1]), .cnt_out(cnt[i+1]), .found_out(found[i+1]),
         .idx_out(idx[i+1])
      );
   end

   always_ff @(posedge clock) begin
      start_ff <= accept;
      if (accept) begin
         status_ff <= ST_OK;
         scan_ff   <= 1'b0;
         hour_ff   <= req_hour;
         min_ff    <= req_minute;
         case (req_opcode)
            OP_ADD: begin
               if (count_ff == FULL) status_ff <= ST_FULL;
               else count_ff <= count_ff + 1'b1;
            end
            OP_DELETE: begin
               if (bad_index) status_ff <= ST_BAD_INDEX;
               else count_ff <= count_ff - 1'b1;
            end
            OP_TICK: begin
               wd_ff <= req_weekday;
               if ({1'b0, req_minute} != last_min_ff) begin
                  scan_ff     <= 1'b1;
                  last_min_ff <= {1'b0, req_minute};
               end
            end
            default: ;
         endcase
      end
      if (accept) begin
         busy_ff <= 1'b1;
      end else if (tok[TABLE_DEPTH]) begin
         busy_ff <= 1'b0;
      end
      if (tok[TABLE_DEPTH]) begin
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= status_ff;
         rsp_fired_ff  <= found[TABLE_DEPTH];
         rsp_idx_ff    <= found[TABLE_DEPTH] ? 6'(idx[TABLE_DEPTH]) : 6'd0;
         rsp_total_ff  <= 7'(count_ff);
         rsp_today_ff  <= 7'(cnt[TABLE_DEPTH]);
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= 1'b0;
         count_ff     <= '0;
         last_min_ff  <= 7'd127;
         wd_ff        <= 3'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_index = rsp_idx_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_today_total = rsp_today_ff;

endmodule

### sv/atm_checker.sv
// Port-level checks for the alarm table matcher, bound to the top level.
// Depends on alarm_table_minute_matcher only through its ports.
module atm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_fired,
   input logic [5:0] rsp_fired_index,
   input logic [6:0] rsp_entry_total,
   input logic [6:0] rsp_today_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during a walk");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == 2'd0)
      else $error("fire reported with error status");

   a_today_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_total != 7'd64 |-> rsp_today_total <= rsp_entry_total)
      else $error("today count exceeds table count");

endmodule

bind alarm_table_minute_matcher atm_checker u_atm_checker (.*);

### tb/sv/alarm_table_minute_matcher_tb.sv
// Testbench for the alarm table minute matcher: directed table then random traffic,
// every result checked against a behavioural model of the table held here.
// Depends on atm_pkg and alarm_table_minute_matcher.
module alarm_table_minute_matcher_tb;
   import atm_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int LIMIT = 2_000_000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_opcode;
   logic [4:0] req_hour;
   logic [5:0] req_minute;
   logic [2:0] req_weekday;
   logic       req_repeating;
   logic [5:0] req_entry_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic       rsp_fired;
   logic [5:0] rsp_fired_index;
   logic [6:0] rsp_entry_total;
   logic [6:0] rsp_today_total;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] wd;
      logic       rp;
      logic [5:0] idx;
   } alarm_req_t;

   typedef struct packed {
      logic [1:0] status;
      logic       fired;
      logic [5:0] fidx;
      logic [6:0] total;
      logic [6:0] today;
   } alarm_rsp_t;

   // directed row: request, with an optional hand-typed answer
   typedef struct packed {
      alarm_req_t r;
      logic       typed;
      alarm_rsp_t a;
   } plan_row_t;

   alarm_table_minute_matcher uut (.*);

   // model state of the table
   entry_type  alarm_tbl [DEPTH];
   int         alarm_cnt;
   int         seen_min;
   logic [2:0] cur_wd;

   alarm_rsp_t pending_rsp[$];
   int         n_bad;
   int         cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit applies_today(entry_type e, logic [2:0] wd);
      if (!e.en) return 1'b0;
      if (e.rp) return e.wd == wd;
      return 1'b1;
   endfunction

   // advance the model by one request, returning the answer it gives
   function automatic alarm_rsp_t alarm_predict(alarm_req_t q);
      alarm_rsp_t o;
      int n;
      o = '0;
      case (q.op)
         OP_ADD: begin
            if (alarm_cnt >= DEPTH) o.status = ST_FULL;
            else begin
               alarm_tbl[alarm_cnt] = {1'b1, q.hour, q.minute, q.rp, q.wd};
               alarm_cnt++;
            end
         end
         OP_DELETE: begin
            if (q.idx >= alarm_cnt) o.status = ST_BAD_INDEX;
            else begin
               for (int i = q.idx; i + 1 < alarm_cnt; i++) alarm_tbl[i] = alarm_tbl[i+1];
               alarm_cnt--;
            end
         end
         OP_TICK: begin
            cur_wd = q.wd;
            if (q.minute != seen_min) begin
               seen_min = q.minute;
               for (int i = 0; i < alarm_cnt; i++) begin
                  if (alarm_tbl[i].en && alarm_tbl[i].hour == q.hour &&
                      alarm_tbl[i].minute == q.minute && applies_today(alarm_tbl[i], q.wd)) begin
                     o.fired = 1'b1;
                     o.fidx  = 6'(i);
                     if (!alarm_tbl[i].rp) alarm_tbl[i].en = 1'b0;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      n = 0;
      for (int i = 0; i < alarm_cnt; i++) if (applies_today(alarm_tbl[i], cur_wd)) n++;
      o.total = 7'(alarm_cnt);
      o.today = 7'(n);
      return o;
   endfunction

   // one transfer on the request side, gap of the given length first
   task automatic send_req(alarm_req_t q, int gap);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= q.op;
      req_hour        <= q.hour;
      req_minute      <= q.minute;
      req_weekday     <= q.wd;
      req_repeating   <= q.rp;
      req_entry_index <= q.idx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic alarm_req_t mk(logic [1:0] op, int h, int m, int wd, int rp, int ix);
      alarm_req_t q;
      q = {op, h[4:0], m[5:0], wd[2:0], rp[0], ix[5:0]};
      return q;
   endfunction

   // random request: mostly in range, now and then raw-bit noise
   function automatic alarm_req_t rand_req();
      alarm_req_t q;
      int pick;
      q = 23'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) return q;
      q.hour   = 5'($urandom_range(0, 3));      // narrow time window so ticks match
      q.minute = 6'($urandom_range(0, 5));
      q.wd     = 3'($urandom_range(0, 6));
      if (pick < 6) begin
         q.hour   = 5'($urandom_range(0, 31));
         q.minute = 6'($urandom_range(0, 63));
         q.wd     = 3'($urandom);
      end
      if (pick < 45) q.op = OP_ADD;
      else if (pick < 60) q.op = OP_DELETE;
      else if (pick < 98) q.op = OP_TICK;
      else q.op = 2'd3;
      q.idx = (pick & 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, alarm_cnt));
      return q;
   endfunction

   // prediction happens at the accepting edge, in transfer order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_rsp.push_back(alarm_predict({req_opcode, req_hour, req_minute,
                                              req_weekday, req_repeating, req_entry_index}));
   end

   always @(posedge clock) begin
      alarm_rsp_t got, exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_fired, rsp_fired_index, rsp_entry_total, rsp_today_total};
         if (pending_rsp.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result %h", got);
         end else begin
            exp_r = pending_rsp.pop_front();
            if (got !== exp_r) begin
               n_bad++;
               if (n_bad <= 10)
                  $display({"mismatch: exp st=%0d f=%0d fi=%0d tot=%0d td=%0d,",
                            " got st=%0d f=%0d fi=%0d tot=%0d td=%0d"},
                           exp_r.status, exp_r.fired, exp_r.fidx, exp_r.total, exp_r.today,
                           got.status, got.fired, got.fidx, got.total, got.today);
            end
         end
      end
   end

   // typed answers from the directed rows are checked on top of the model
   alarm_rsp_t typed_q[$];
   bit         typed_on[$];
   always @(posedge clock) begin
      alarm_rsp_t got, t;
      bit on;
      if (!reset && rsp_valid && rsp_ready && typed_on.size() != 0) begin
         on = typed_on.pop_front();
         t  = typed_q.pop_front();
         got = {rsp_status, rsp_fired, rsp_fired_index, rsp_entry_total, rsp_today_total};
         if (on && got !== t) begin
            n_bad++;
            if (n_bad <= 10) $display("directed row: exp %h got %h", t, got);
         end
      end
   end

   // receiver stalls: alternates between free-running and patterned stretches
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b1;
      else if (cycles % 3000 < 800) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0) && ((cycles % 7) != 3);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("alarm_table_minute_matcher_tb: FAIL");
         $finish;
      end
   end

   initial begin
      plan_row_t plan[$];
      alarm_req_t q;
      int burst;
      cycles = 0; n_bad = 0;
      alarm_cnt = 0; seen_min = 127; cur_wd = '0;
      reset = 1'b1; req_valid = 1'b0; rsp_ready = 1'b1;
      req_opcode = '0; req_hour = '0; req_minute = '0; req_weekday = '0;
      req_repeating = '0; req_entry_index = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty-table cases, extremes and the special cases of the spec
      plan.push_back({mk(OP_DELETE, 0, 0, 0, 0, 0), 1'b1, 2'(ST_BAD_INDEX), 1'b0, 6'd0, 7'd0, 7'd0});
      plan.push_back({mk(OP_TICK, 0, 0, 0, 0, 0), 1'b1, 2'(ST_OK), 1'b0, 6'd0, 7'd0, 7'd0});
      plan.push_back({mk(2'd3, 31, 63, 7, 1, 63), 1'b1, 2'(ST_OK), 1'b0, 6'd0, 7'd0, 7'd0});
      plan.push_back({mk(OP_ADD, 23, 59, 6, 1, 63), 1'b1, 2'(ST_OK), 1'b0, 6'd0, 7'd1, 7'd0});
      plan.push_back({mk(OP_ADD, 0, 0, 0, 0, 0), 1'b1, 2'(ST_OK), 1'b0, 6'd0, 7'd2, 7'd1});
      plan.push_back({mk(OP_ADD, 31, 63, 7, 1, 0), 1'b0, 23'd0});
      plan.push_back({mk(OP_ADD, 5, 10, 3, 0, 0), 1'b0, 23'd0});
      plan.push_back({mk(OP_TICK, 23, 59, 6, 0, 0), 1'b0, 23'd0});  // repeat fires
      plan.push_back({mk(OP_TICK, 23, 59, 6, 0, 0), 1'b0, 23'd0});  // same minute: no scan
      plan.push_back({mk(OP_TICK, 31, 63, 7, 0, 0), 1'b0, 23'd0});  // out-of-range raw match
      plan.push_back({mk(OP_TICK, 5, 10, 2, 0, 0), 1'b0, 23'd0});   // one-shot fires, disabled
      plan.push_back({mk(OP_TICK, 5, 11, 2, 0, 0), 1'b0, 23'd0});
      plan.push_back({mk(OP_TICK, 5, 10, 2, 0, 0), 1'b0, 23'd0});   // no re-fire
      plan.push_back({mk(OP_DELETE, 0, 0, 0, 0, 4), 1'b0, 23'd0});  // at count: bad index
      plan.push_back({mk(OP_DELETE, 0, 0, 0, 0, 63), 1'b0, 23'd0});
      plan.push_back({mk(OP_DELETE, 0, 0, 0, 0, 3), 1'b0, 23'd0});  // last entry
      plan.push_back({mk(OP_DELETE, 0, 0, 0, 0, 0), 1'b0, 23'd0});  // first entry, shift
      foreach (plan[i]) begin
         typed_on.push_back(plan[i].typed);
         typed_q.push_back(plan[i].a);
         send_req(plan[i].r, $urandom_range(0, 2));
      end
      // fill to the top, three adds past full, then ticks and a drain at random positions
      for (int i = 0; i < DEPTH + 1; i++) begin
         typed_on.push_back(1'b0); typed_q.push_back('0);
         send_req(mk(OP_ADD, $urandom_range(0, 2), $urandom_range(0, 3),
                     $urandom_range(0, 6), $urandom_range(0, 1), 0), 0);
      end
      for (int i = 0; i < 4; i++) begin
         typed_on.push_back(1'b0); typed_q.push_back('0);
         send_req(mk(OP_TICK, $urandom_range(0, 2), i, $urandom_range(0, 6), 0, 0), 0);
      end
      while (alarm_cnt > 8) begin
         typed_on.push_back(1'b0); typed_q.push_back('0);
         send_req(mk(OP_DELETE, 0, 0, 0, 0, $urandom_range(0, alarm_cnt - 1)), 0);
      end

      // random traffic in bursts
      for (int n = 0; n < 600; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && n < 600; b++, n++) begin
            q = rand_req();
            typed_on.push_back(1'b0); typed_q.push_back('0);
            send_req(q, (b == 0) ? $urandom_range(0, 12) : 0);
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      if (n_bad == 0 && pending_rsp.size() == 0)
         $display("alarm_table_minute_matcher_tb: PASS");
      else
         $display("alarm_table_minute_matcher_tb: FAIL");
      $finish;
   end

endmodule
